// ===== rtl/wsf_pkg.sv =====
// wsf_pkg: shared widths, register indexes, job and handshake structs and the
// back-end state type for the weighted source fusion block.
// No dependencies; every other file depends on it.
`timescale 1ns / 1ps
`default_nettype none

package wsf_pkg;

    // Sources counted per pixel; words past this are ignored.
    localparam int MAX_SOURCES = 16;

    localparam int SV_W   = 32;                            // sample width
    localparam int WT_W   = 17;                            // Q1.15 weight, signed
    localparam int LOG_N  = $clog2(MAX_SOURCES);
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);       // source / valid counters
    localparam int DS_W   = 4;                             // default_source width
    localparam int CMP_W  = (CNT_W > DS_W) ? CNT_W : DS_W;
    localparam int PROD_W = SV_W + WT_W;                   // sample * weight
    localparam int WSUM_W = PROD_W + LOG_N;                // weighted sum
    localparam int TSUM_W = (WT_W - 1) + LOG_N;            // weight sum, never negative
    localparam int PSUM_W = SV_W + LOG_N;                  // plain sum
    localparam int STEP_W = $clog2(WSUM_W + 1);            // divider step counter

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FUSION_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SOURCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_VALUE  = 2'd2;

    localparam logic [SV_W-1:0] RESET_INVALID_VALUE = '0;

    localparam logic MODE_MEAN   = 1'b0;
    localparam logic MODE_WINNER = 1'b1;

    typedef struct packed {
        logic            fusion_mode;
        logic [DS_W-1:0] default_source;
        logic [SV_W-1:0] invalid_value;
    } t_cfg;

    typedef enum logic {
        JOB_PASS,   // result already known, goes straight out
        JOB_DIV     // result is dividend / divisor
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [SV_W-1:0]   value;
        logic              no_valid;
        logic [WSUM_W-1:0] dividend;   // two's complement
        logic [TSUM_W-1:0] divisor;    // nonzero for JOB_DIV
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_word;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic load_pass;
        logic start;
        logic step;
        logic load_div;
    } t_back_ctl;

endpackage

`default_nettype wire

// ===== rtl/wsf_if.sv =====
// wsf_if: valid/ready channel interfaces for source words and fused words.
// Depends on wsf_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface wsf_in_if;
    import wsf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [SV_W-1:0] sample_value;
    logic signed [WT_W-1:0] weight;
    logic                   last_source;

    modport source (output valid, sample_value, weight, last_source, input ready);
    modport sink   (input valid, sample_value, weight, last_source, output ready);
endinterface

interface wsf_out_if;
    import wsf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [SV_W-1:0] fused_value;
    logic                   no_valid_source;

    modport source (output valid, fused_value, no_valid_source, input ready);
    modport sink   (input valid, fused_value, no_valid_source, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsf_front.sv =====
// wsf_front: registers each source word with its product, accumulates the
// pixel and turns the finished pixel into a job for the back end.
// Depends on wsf_pkg and wsf_if.
`timescale 1ns / 1ps
`default_nettype none

module wsf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    wsf_in_if.sink               i_src,
    input  wire wsf_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_full,
    output wsf_pkg::t_q_word     o_push
);
    import wsf_pkg::*;

    // product stage
    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_p_prod;
    logic signed [SV_W-1:0]   r_p_value;
    logic signed [WT_W-1:0]   r_p_weight;
    logic                     r_p_last;

    // pixel accumulators
    logic [CNT_W-1:0]         r_cnt,    n_cnt;
    logic [CNT_W-1:0]         r_vcnt,   n_vcnt;
    logic signed [WSUM_W-1:0] r_wsum,   n_wsum;
    logic [TSUM_W-1:0]        r_tsum,   n_tsum;
    logic signed [PSUM_W-1:0] r_psum,   n_psum;
    logic signed [WT_W-1:0]   r_best_w, n_best_w;
    logic signed [SV_W-1:0]   r_best_v, n_best_v;
    logic signed [WT_W-1:0]   r_def_w,  n_def_w;
    logic signed [SV_W-1:0]   r_def_v,  n_def_v;
    logic                     r_def_seen, n_def_seen;

    logic signed [PROD_W-1:0] w_prod;
    logic                     p_take;
    logic                     counted;
    logic                     w_ok;
    logic                     use_def;
    logic signed [WT_W-1:0]   win_w;
    logic signed [SV_W-1:0]   win_v;
    t_job                     job;

    assign w_prod      = i_src.sample_value * i_src.weight;
    assign p_take      = r_p_valid && (!r_p_last || !i_q_full);
    assign i_src.ready = !r_p_valid || p_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_src.ready) begin
            r_p_valid <= i_src.valid;
        end
        if (i_src.valid && i_src.ready) begin
            r_p_prod   <= w_prod;
            r_p_value  <= i_src.sample_value;
            r_p_weight <= i_src.weight;
            r_p_last   <= i_src.last_source;
        end
    end

    // accumulate the word sitting in the product stage
    always_comb begin
        counted    = r_cnt < CNT_W'(MAX_SOURCES);
        w_ok       = counted && !r_p_weight[WT_W-1];
        n_cnt      = r_cnt + CNT_W'(counted);
        n_vcnt     = r_vcnt + CNT_W'(w_ok);
        n_wsum     = r_wsum + (w_ok ? {{LOG_N{r_p_prod[PROD_W-1]}}, r_p_prod}
                                    : WSUM_W'(0));
        n_tsum     = r_tsum + (w_ok ? TSUM_W'(r_p_weight[WT_W-2:0]) : TSUM_W'(0));
        n_psum     = r_psum + (w_ok ? {{LOG_N{r_p_value[SV_W-1]}}, r_p_value}
                                    : PSUM_W'(0));
        n_best_w   = r_best_w;
        n_best_v   = r_best_v;
        n_def_w    = r_def_w;
        n_def_v    = r_def_v;
        n_def_seen = r_def_seen;
        if (counted && (r_cnt == '0 || r_p_weight > r_best_w)) begin
            n_best_w = r_p_weight;
            n_best_v = r_p_value;
        end
        if (counted && CMP_W'(r_cnt) == CMP_W'(i_cfg.default_source)) begin
            n_def_w    = r_p_weight;
            n_def_v    = r_p_value;
            n_def_seen = 1'b1;
        end
    end

    // classify the finished pixel
    always_comb begin
        use_def      = n_def_seen && (n_def_w >= n_best_w);
        win_w        = use_def ? n_def_w : n_best_w;
        win_v        = use_def ? n_def_v : n_best_v;
        job.kind     = JOB_PASS;
        job.value    = i_cfg.invalid_value;
        job.no_valid = 1'b1;
        job.dividend = n_wsum;
        job.divisor  = n_tsum;
        if (i_cfg.fusion_mode == MODE_WINNER) begin
            if (!win_w[WT_W-1]) begin
                job.value    = win_v;
                job.no_valid = 1'b0;
            end
        end else if (n_vcnt != '0) begin
            job.kind     = JOB_DIV;
            job.no_valid = 1'b0;
            if (n_tsum == '0) begin
                // every valid weight zero: plain mean
                job.dividend = {{(WSUM_W-PSUM_W){n_psum[PSUM_W-1]}}, n_psum};
                job.divisor  = TSUM_W'(n_vcnt);
            end
        end
    end

    assign o_push.valid = p_take && r_p_last;
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (p_take && r_p_last)) begin
            r_cnt      <= '0;
            r_vcnt     <= '0;
            r_wsum     <= '0;
            r_tsum     <= '0;
            r_psum     <= '0;
            r_best_w   <= '0;
            r_best_v   <= '0;
            r_def_w    <= '0;
            r_def_v    <= '0;
            r_def_seen <= 1'b0;
        end else if (p_take) begin
            r_cnt      <= n_cnt;
            r_vcnt     <= n_vcnt;
            r_wsum     <= n_wsum;
            r_tsum     <= n_tsum;
            r_psum     <= n_psum;
            r_best_w   <= n_best_w;
            r_best_v   <= n_best_v;
            r_def_w    <= n_def_w;
            r_def_v    <= n_def_v;
            r_def_seen <= n_def_seen;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsf_queue.sv =====
// wsf_queue: short job queue between the front end and the back end.
// Depends on wsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wsf_pkg::t_q_word i_push,
    output logic                  o_full,
    input  wire logic             i_pop,
    output wsf_pkg::t_q_word      o_head
);
    import wsf_pkg::*;

    t_job              r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full       = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.job   = r_slot[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsf_back.sv =====
// wsf_back: executes jobs: passes known results through or runs the
// radix-2 restoring divider, then holds the fused word in the output register.
// Depends on wsf_pkg and wsf_if.
`timescale 1ns / 1ps
`default_nettype none

module wsf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wsf_pkg::t_q_word i_head,
    output logic                  o_pop,
    wsf_out_if.source             o_fus
);
    import wsf_pkg::*;

    t_back_state       r_state, n_state;
    t_back_ctl         ctl;

    logic [TSUM_W-1:0] r_rem;
    logic [WSUM_W-1:0] r_quo;
    logic [TSUM_W-1:0] r_div;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic [SV_W-1:0]   r_out_value;
    logic              r_out_nvs;

    logic              out_free;
    logic [TSUM_W:0]   trial;
    logic [TSUM_W:0]   diff;
    logic              ge;
    logic [SV_W-1:0]   quo_lo;

    assign out_free = !r_out_valid || o_fus.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_head.valid && i_head.job.kind == JOB_DIV) n_state = BK_DIV;
            BK_DIV:  if (r_step == STEP_W'(1)) n_state = BK_DONE;
            BK_DONE: if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid && i_head.job.kind == JOB_DIV) begin
                    ctl.start = 1'b1;
                    ctl.pop   = 1'b1;
                end else if (i_head.valid && out_free) begin
                    ctl.load_pass = 1'b1;
                    ctl.pop       = 1'b1;
                end
            end
            BK_DIV:  ctl.step     = 1'b1;
            BK_DONE: ctl.load_div = out_free;
            default: ctl = '0;
        endcase
    end

    assign o_pop = ctl.pop;

    // one quotient bit per cycle
    assign trial  = {r_rem, r_quo[WSUM_W-1]};
    assign diff   = trial - {1'b0, r_div};
    assign ge     = trial >= {1'b0, r_div};
    assign quo_lo = r_quo[SV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (ctl.start) begin
            r_neg  <= i_head.job.dividend[WSUM_W-1];
            r_quo  <= i_head.job.dividend[WSUM_W-1] ? -i_head.job.dividend
                                                    : i_head.job.dividend;
            r_rem  <= '0;
            r_div  <= i_head.job.divisor;
            r_step <= STEP_W'(WSUM_W);
        end else if (ctl.step) begin
            r_rem  <= ge ? diff[TSUM_W-1:0] : trial[TSUM_W-1:0];
            r_quo  <= {r_quo[WSUM_W-2:0], ge};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load_pass || ctl.load_div) begin
            r_out_valid <= 1'b1;
        end else if (o_fus.ready) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.load_pass) begin
            r_out_value <= i_head.job.value;
            r_out_nvs   <= i_head.job.no_valid;
        end else if (ctl.load_div) begin
            r_out_value <= r_neg ? -quo_lo : quo_lo;
            r_out_nvs   <= 1'b0;
        end
    end

    assign o_fus.valid           = r_out_valid;
    assign o_fus.fused_value     = r_out_value;
    assign o_fus.no_valid_source = r_out_nvs;

endmodule

`default_nettype wire

// ===== rtl/weighted_source_fusion.sv =====
// weighted_source_fusion: top level; configuration registers, front end,
// job queue and back end. Depends on wsf_pkg, wsf_if, wsf_front, wsf_queue, wsf_back.
`timescale 1ns / 1ps
`default_nettype none

// Fuses one sample per pixel from up to MAX_SOURCES sources. Each pixel arrives
// on i_src as a run of words (sample_value, Q1.15 weight, last_source), one per
// source in source order; a negative weight marks a source invalid. One fused
// word leaves on o_fus per pixel, at the word carrying last_source. Mean mode
// gives sum(w*v)/sum(w) over the valid sources truncated toward zero (the plain
// mean if all valid weights are zero); winner mode gives the sample with the
// highest weight, default_source winning ties. With nothing usable the block
// sends invalid_value and raises no_valid_source. Words past MAX_SOURCES in a
// pixel are dropped, but their last_source still closes the pixel.
// Timing: the front end takes one source word per cycle unless a pixel-closing
// word meets a full queue, and hands each closed pixel to a two-deep job queue.
// The back end loads a winner-mode pixel, or one with no valid source, into the
// output register once it is free; a mean-mode pixel occupies the shared
// restoring divider for WSUM_W (53) steps. Source words keep being taken while
// the divider runs, until the queue fills. The output register lets the back
// end run the divider for the next pixel while the current fused word waits.
// Registers (i_cfg_we, i_cfg_idx, i_cfg_data) must be written by the user only
// while idle; the block does not enforce it. Index 0 fusion_mode,
// 1 default_source, 2 invalid_value; index 3 is ignored.
module weighted_source_fusion (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    wsf_in_if.sink                                i_src,
    wsf_out_if.source                             o_fus,
    input  wire logic                             i_cfg_we,
    input  wire logic [wsf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [wsf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wsf_pkg::*;

    t_cfg     r_cfg;
    t_q_word  push;
    t_q_word  head;
    logic     q_full;
    logic     pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fusion_mode    <= MODE_MEAN;
            r_cfg.default_source <= '0;
            r_cfg.invalid_value  <= RESET_INVALID_VALUE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FUSION_MODE:    r_cfg.fusion_mode    <= i_cfg_data[0];
                CFG_DEFAULT_SOURCE: r_cfg.default_source <= i_cfg_data[DS_W-1:0];
                CFG_INVALID_VALUE:  r_cfg.invalid_value  <= i_cfg_data[SV_W-1:0];
                default: ;
            endcase
        end
    end

    wsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    wsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    wsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_fus   (o_fus)
    );

endmodule

`default_nettype wire

// ===== rtl/wsf_checker.sv =====
// wsf_checker: port-level checks on the fusion block, bound to the top level.
// Depends on wsf_pkg for the payload width.
`timescale 1ns / 1ps
`default_nettype none

module wsf_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_ready,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic [wsf_pkg::SV_W-1:0]  i_out_value,
    input  wire logic                      i_out_nvs
);
    // reset empties the output register
    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("fused word valid right after reset");

    // reset empties the product stage, so a source word can be taken at once
    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("source channel not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("fused word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_nvs))
        else $error("fused word changed while stalled");

endmodule

bind weighted_source_fusion wsf_checker u_wsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_fus.valid),
    .i_out_ready (o_fus.ready),
    .i_out_value (o_fus.fused_value),
    .i_out_nvs   (o_fus.no_valid_source)
);

`default_nettype wire
